// ===== rtl/core/latency_jitter_statistics_macros.svh =====
// Assertion macros for the latency and jitter statistics block.
// Used by modules that have a clk and an active-low rst_n in scope.
`ifndef LATENCY_JITTER_STATISTICS_MACROS_SVH
`define LATENCY_JITTER_STATISTICS_MACROS_SVH
`ifndef SYNTHESIS
`define LJS_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");
`define LJS_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence check failed");
`else
`define LJS_CHECK(label, cond)
`define LJS_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/lj_pkg.sv =====
// Shared constants, register indexes and rank tables for the latency statistics block.
// No dependencies.
package lj_pkg;

    localparam int WINDOW   = 64;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int SAMPLE_W = 32;
    localparam int BIT_W    = $clog2(SAMPLE_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MIN_FILL   = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FAST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SLOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_RATIO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_FACTOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LATENCY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_ENVELOPE = 3'd6;

    // Reset values of the configuration registers
    localparam logic [16:0] RST_ALPHA_FAST     = 17'd19661;
    localparam logic [16:0] RST_ALPHA_SLOW     = 17'd3277;
    localparam logic [15:0] RST_SPIKE_RATIO    = 16'd768;
    localparam logic [15:0] RST_VAR_FACTOR     = 16'd128;
    localparam logic [31:0] RST_TARGET_LATENCY = 32'd1048576;
    localparam logic [31:0] RST_TAIL_LIMIT     = 32'd2162688;
    localparam logic [16:0] RST_DRIFT_ENVELOPE = 17'd6554;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Percentile rank k = round(pct * (fill - 1) / 100), half rounds up
    localparam int PCT_P95  = 95;
    localparam int PCT_P99  = 99;
    localparam int PCT_DEN  = 100;
    localparam int PCT_HALF = 50;

    typedef logic [FILL_W-1:0] rank_tab_t [WINDOW+1];

    function automatic rank_tab_t build_rank(int pct);
        rank_tab_t tab;
        for (int n = 0; n <= WINDOW; n++)
        begin
            if (n == 0)
                tab[n] = '0;
            else
                tab[n] = FILL_W'((pct * (n - 1) + PCT_HALF) / PCT_DEN);
        end
        return tab;
    endfunction

    localparam rank_tab_t RANK95_TAB = build_rank(PCT_P95);
    localparam rank_tab_t RANK99_TAB = build_rank(PCT_P99);

endpackage

// ===== rtl/core/lj_sample_if.sv =====
// Sample channel: valid/ready handshake carrying one latency sample.
// Depends on lj_pkg.
interface lj_sample_if;
    import lj_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/lj_result_if.sv =====
// Result channel: valid/ready handshake carrying one full statistics record.
// No dependencies.
interface lj_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] mean_value;
    logic [63:0] variance_value;
    logic [31:0] p95_value;
    logic [31:0] p99_value;
    logic [31:0] worst_value;
    logic [31:0] best_value;
    logic [31:0] ema_fast_value;
    logic [31:0] ema_slow_value;
    logic [31:0] sample_total;
    logic [31:0] spike_total;
    logic [3:0]  instability;

    modport source (output valid, output mean_value, output variance_value,
                    output p95_value, output p99_value, output worst_value,
                    output best_value, output ema_fast_value, output ema_slow_value,
                    output sample_total, output spike_total, output instability,
                    input ready);
    modport sink   (input valid, input mean_value, input variance_value,
                    input p95_value, input p99_value, input worst_value,
                    input best_value, input ema_fast_value, input ema_slow_value,
                    input sample_total, input spike_total, input instability,
                    output ready);
endinterface

// ===== rtl/core/latency_jitter_statistics.sv =====
// Top level: sequencer, statistics state and output register of the latency block.
// Depends on lj_pkg, lj_sample_if, lj_result_if, lj_div, lj_mul, lj_select and the macros.
//
//  channel   | role   | payload
//  samples   | sink   | sample (Q16.16 ms)
//  results   | source | mean, variance, p95, p99, worst, best, emas, totals, instability
//  cfg_*     | write  | cfg_index selects one of seven registers
//
// Between a sample's transfer and the next ready: the mean-step divide, twelve products on
// the shared multiplier, the variance divide (skipped on the first sample) and sequencing.
// Once eight slots are filled the percentile select adds one pass over the filled slots per
// sample bit, one memory read a cycle. Reset clears the statistics but sets best to all ones;
// the window memory is never cleared, only filled slots are read. A full output register
// stalls the sequencer; the next sample is taken once it loads.
`include "latency_jitter_statistics_macros.svh"
module latency_jitter_statistics (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [lj_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lj_pkg::CFG_DATA_W-1:0] cfg_wdata,
    lj_sample_if.sink                     samples,
    lj_result_if.source                   results
);
    import lj_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MEAN_DIV = 9'b000000010,
        ST_D2       = 9'b000000100,
        ST_MUL      = 9'b000001000,
        ST_VAR_GO   = 9'b000010000,
        ST_VAR_DIV  = 9'b000100000,
        ST_SEL_GO   = 9'b001000000,
        ST_SEL      = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        OP_SQ, OP_FA, OP_FB, OP_SA, OP_SB, OP_SPL, OP_SPH,
        OP_KT, OP_KLL, OP_KHL, OP_KHH, OP_DR
    } mul_op_t;

    // Configuration registers
    logic [16:0] alpha_fast_reg, alpha_slow_reg, drift_env_reg;
    logic [15:0] spk_ratio_reg, var_factor_reg;
    logic [31:0] target_reg, tail_reg;

    // Statistics state
    state_t          state_reg;
    mul_op_t         op_reg;
    logic            phase_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [31:0] count_reg, spike_cnt_reg;
    logic [47:0] mean_reg;
    logic [63:0] sq_reg;
    logic [31:0] ef_reg, es_reg, worst_reg, best_reg, p95_reg, p99_reg;

    // Per-sample working registers
    logic [31:0] s_reg;
    logic        neg_reg;
    logic [47:0] d1_reg;
    logic [31:0] d2h_reg;
    logic [63:0] acc_reg;
    logic        spike_hit_reg;
    logic [47:0] kt_reg;
    logic [95:0] k2_reg;
    logic [48:0] drift_lim_reg;
    logic [63:0] var_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] o_mean_reg, o_p95_reg, o_p99_reg, o_worst_reg, o_best_reg;
    logic [31:0] o_ef_reg, o_es_reg, o_count_reg, o_spike_reg;
    logic [63:0] o_var_reg;
    logic [3:0]  o_mask_reg;

    // Combinational helpers
    logic        accept;
    logic [47:0] s48_in, s48_reg, d1_now, d2_now;
    logic        neg_now;
    logic [31:0] count_next;
    logic [16:0] af, as_w;
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_q;
    logic [31:0] div_divisor;
    logic        sel_start, sel_done;
    logic [31:0] sel_p95, sel_p99;
    logic [64:0] sq_sum;
    logic [49:0] ema_sum;
    logic [63:0] spike_prod;
    logic [31:0] gap;
    logic [3:0]  mask;
    logic        out_load;
    logic [47:0] mean_upd;

    assign accept = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    // Mean step operands and saturating count
    always_comb
    begin
        s48_in     = {samples.sample, 16'b0};
        s48_reg    = {s_reg, 16'b0};
        neg_now    = s48_in < mean_reg;
        d1_now     = neg_now ? mean_reg - s48_in : s48_in - mean_reg;
        d2_now     = (s48_reg < mean_reg) ? mean_reg - s48_reg : s48_reg - mean_reg;
        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        af         = (alpha_fast_reg > ONE_Q16) ? ONE_Q16 : alpha_fast_reg;
        as_w       = (alpha_slow_reg > ONE_Q16) ? ONE_Q16 : alpha_slow_reg;
        mean_upd   = neg_reg ? mean_reg - div_q[47:0] : mean_reg + div_q[47:0];
    end

    // Divider requests: mean step on accept, variance later
    always_comb
    begin
        div_start    = accept || (state_reg == ST_VAR_GO && count_reg >= 32'd2);
        div_dividend = (state_reg == ST_IDLE) ? {16'b0, d1_now} : sq_reg;
        div_divisor  = (state_reg == ST_IDLE) ? count_next : count_reg - 1'b1;
        sel_start    = (state_reg == ST_SEL_GO) && (fill_reg >= FILL_W'(MIN_FILL));
    end

    // Multiplier operand select
    always_comb
    begin
        unique case (op_reg)
            OP_SQ:   begin mul_a = {1'b0, d1_reg[47:16]};  mul_b = {1'b0, d2h_reg};        end
            OP_FA:   begin mul_a = {16'b0, af};            mul_b = {1'b0, s_reg};          end
            OP_FB:   begin mul_a = {16'b0, ONE_Q16 - af};  mul_b = {1'b0, ef_reg};         end
            OP_SA:   begin mul_a = {16'b0, as_w};          mul_b = {1'b0, s_reg};          end
            OP_SB:   begin mul_a = {16'b0, ONE_Q16 - as_w}; mul_b = {1'b0, es_reg};        end
            OP_SPL:  begin mul_a = {17'b0, spk_ratio_reg}; mul_b = {1'b0, mean_reg[31:0]}; end
            OP_SPH:  begin mul_a = {17'b0, spk_ratio_reg}; mul_b = {17'b0, mean_reg[47:32]}; end
            OP_KT:   begin mul_a = {17'b0, var_factor_reg}; mul_b = {1'b0, target_reg};    end
            OP_KLL:  begin mul_a = {1'b0, kt_reg[31:0]};   mul_b = {1'b0, kt_reg[31:0]};   end
            OP_KHL:  begin mul_a = {17'b0, kt_reg[47:32]}; mul_b = {1'b0, kt_reg[31:0]};   end
            OP_KHH:  begin mul_a = {17'b0, kt_reg[47:32]}; mul_b = {17'b0, kt_reg[47:32]}; end
            OP_DR:   begin mul_a = {16'b0, drift_env_reg}; mul_b = {1'b0, target_reg};    end
            default: begin mul_a = '0;                     mul_b = '0;                     end
        endcase
    end

    // Combine partial products and build the instability mask
    always_comb
    begin
        sq_sum     = {1'b0, sq_reg} + {1'b0, prod[63:0]};
        ema_sum    = {1'b0, acc_reg[48:0]} + {1'b0, prod[48:0]};
        spike_prod = acc_reg + {prod[31:0], 32'b0};
        gap        = (ef_reg > es_reg) ? ef_reg - es_reg : es_reg - ef_reg;
        mask       = '0;
        if (count_reg >= 32'd4)
        begin
            mask[0] = spike_hit_reg;
            mask[1] = {16'b0, var_reg, 16'b0} > k2_reg;
            mask[2] = {1'b0, gap, 16'b0} > drift_lim_reg;
            mask[3] = (p99_reg > tail_reg) && (fill_reg >= FILL_W'(MIN_FILL));
        end
        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);
    end

    lj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    lj_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    lj_select u_select (
        .clk   (clk),
        .rst_n (rst_n),
        .wen   (accept),
        .waddr (slot_reg),
        .wdata (samples.sample),
        .start (sel_start),
        .fill  (fill_reg),
        .done  (sel_done),
        .p95   (sel_p95),
        .p99   (sel_p99)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_fast_reg  <= RST_ALPHA_FAST;
            alpha_slow_reg  <= RST_ALPHA_SLOW;
            spk_ratio_reg   <= RST_SPIKE_RATIO;
            var_factor_reg  <= RST_VAR_FACTOR;
            target_reg      <= RST_TARGET_LATENCY;
            tail_reg        <= RST_TAIL_LIMIT;
            drift_env_reg   <= RST_DRIFT_ENVELOPE;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_ALPHA_FAST:     alpha_fast_reg  <= cfg_wdata[16:0];
                CFG_ALPHA_SLOW:     alpha_slow_reg  <= cfg_wdata[16:0];
                CFG_SPIKE_RATIO:    spk_ratio_reg   <= cfg_wdata[15:0];
                CFG_VAR_FACTOR:     var_factor_reg  <= cfg_wdata[15:0];
                CFG_TARGET_LATENCY: target_reg      <= cfg_wdata;
                CFG_TAIL_LIMIT:     tail_reg        <= cfg_wdata;
                CFG_DRIFT_ENVELOPE: drift_env_reg   <= cfg_wdata[16:0];
                default:            ;
            endcase
        end
    end

    // Sequencer and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SQ;
            phase_reg     <= 1'b0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            spike_cnt_reg <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            ef_reg        <= '0;
            es_reg        <= '0;
            worst_reg     <= '0;
            best_reg      <= '1;
            p95_reg       <= '0;
            p99_reg       <= '0;
            s_reg         <= '0;
            neg_reg       <= 1'b0;
            d1_reg        <= '0;
            d2h_reg       <= '0;
            acc_reg       <= '0;
            spike_hit_reg <= 1'b0;
            kt_reg        <= '0;
            k2_reg        <= '0;
            drift_lim_reg <= '0;
            var_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Take the sample, advance the window, start the mean divide
                    if (accept)
                    begin
                        s_reg     <= samples.sample;
                        neg_reg   <= neg_now;
                        d1_reg    <= d1_now;
                        count_reg <= count_next;
                        slot_reg  <= (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                        if (fill_reg < FILL_W'(WINDOW))
                            fill_reg <= fill_reg + 1'b1;
                        if (samples.sample > worst_reg)
                            worst_reg <= samples.sample;
                        if (samples.sample < best_reg)
                            best_reg <= samples.sample;
                        state_reg <= ST_MEAN_DIV;
                    end
                end
                ST_MEAN_DIV:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= mean_upd;
                        state_reg <= ST_D2;
                    end
                end
                ST_D2:
                begin
                    d2h_reg   <= d2_now[47:16];
                    op_reg    <= OP_SQ;
                    phase_reg <= 1'b0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        unique case (op_reg)
                            OP_SQ:  sq_reg <= sq_sum[64] ? '1 : sq_sum[63:0];
                            OP_FA:  acc_reg <= prod[63:0];
                            OP_FB:  ef_reg <= (count_reg == 32'd1) ? s_reg : ema_sum[47:16];
                            OP_SA:  acc_reg <= prod[63:0];
                            OP_SB:  es_reg <= (count_reg == 32'd1) ? s_reg : ema_sum[47:16];
                            OP_SPL: acc_reg <= prod[63:0];
                            OP_SPH: spike_hit_reg <= (mean_reg != '0)
                                        && ({8'b0, s_reg, 24'b0} > spike_prod);
                            OP_KT:  kt_reg <= prod[47:0];
                            OP_KLL: k2_reg <= {32'b0, prod[63:0]};
                            OP_KHL: k2_reg <= k2_reg + {15'b0, prod[47:0], 33'b0};
                            OP_KHH: k2_reg <= k2_reg + {prod[31:0], 64'b0};
                            OP_DR:  drift_lim_reg <= prod[48:0];
                            default: ;
                        endcase
                        if (op_reg == OP_DR)
                            state_reg <= ST_VAR_GO;
                        else
                            op_reg <= mul_op_t'(op_reg + 4'd1);
                    end
                end
                ST_VAR_GO:
                begin
                    if (count_reg >= 32'd2)
                        state_reg <= ST_VAR_DIV;
                    else
                    begin
                        var_reg   <= '0;
                        state_reg <= ST_SEL_GO;
                    end
                end
                ST_VAR_DIV:
                begin
                    if (div_done)
                    begin
                        var_reg   <= div_q;
                        state_reg <= ST_SEL_GO;
                    end
                end
                ST_SEL_GO:
                begin
                    state_reg <= sel_start ? ST_SEL : ST_FINISH;
                end
                ST_SEL:
                begin
                    if (sel_done)
                    begin
                        p95_reg   <= sel_p95;
                        p99_reg   <= sel_p99;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        if (count_reg > 32'd1 && spike_hit_reg && spike_cnt_reg != '1)
                            spike_cnt_reg <= spike_cnt_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: hold the record until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_mean_reg  <= mean_reg[47:16];
            o_var_reg   <= var_reg;
            o_p95_reg   <= p95_reg;
            o_p99_reg   <= p99_reg;
            o_worst_reg <= worst_reg;
            o_best_reg  <= best_reg;
            o_ef_reg    <= ef_reg;
            o_es_reg    <= es_reg;
            o_count_reg <= count_reg;
            o_spike_reg <= (count_reg > 32'd1 && spike_hit_reg && spike_cnt_reg != '1)
                           ? spike_cnt_reg + 1'b1 : spike_cnt_reg;
            o_mask_reg  <= mask;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.mean_value     = o_mean_reg;
    assign results.variance_value = o_var_reg;
    assign results.p95_value      = o_p95_reg;
    assign results.p99_value      = o_p99_reg;
    assign results.worst_value    = o_worst_reg;
    assign results.best_value     = o_best_reg;
    assign results.ema_fast_value = o_ef_reg;
    assign results.ema_slow_value = o_es_reg;
    assign results.sample_total   = o_count_reg;
    assign results.spike_total    = o_spike_reg;
    assign results.instability    = o_mask_reg;

    `LJS_CHECK(a_fill_range, fill_reg <= FILL_W'(WINDOW))
    `LJS_CHECK(a_div_done_state, !div_done || state_reg == ST_MEAN_DIV || state_reg == ST_VAR_DIV)
    `LJS_CHECK(a_sel_done_state, !sel_done || state_reg == ST_SEL)
    `LJS_NEXT(a_accept_divides, accept, state_reg == ST_MEAN_DIV)
endmodule

// ===== rtl/core/lj_div.sv =====
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
// Standalone; used for the mean step and the variance.
module lj_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [63:0]      quo_reg;
    logic [31:0]      dvs_reg;
    logic [32:0]      rem_shift;
    logic [32:0]      rem_diff;
    logic             fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[63]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            // Flag the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS - 1);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_diff[31:0] : rem_shift[31:0];
                quo_reg <= {quo_reg[62:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/core/lj_mul.sv =====
// Shared 33x33 unsigned multiplier with a registered product.
// Standalone; operands are chosen by the sequencer.
module lj_mul (
    input  logic        clk,
    input  logic [32:0] op_a,
    input  logic [32:0] op_b,
    output logic [65:0] product
);
    logic [65:0] product_reg;

    // Register every product for the next cycle
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;
endmodule

// ===== rtl/core/lj_select.sv =====
// Window store and bitwise radix select of the 95th and 99th percentiles.
// Depends on lj_pkg.
module lj_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wen,
    input  logic [lj_pkg::IDX_W-1:0]    waddr,
    input  logic [lj_pkg::SAMPLE_W-1:0] wdata,
    input  logic                        start,
    input  logic [lj_pkg::FILL_W-1:0]   fill,
    output logic                        done,
    output logic [lj_pkg::SAMPLE_W-1:0] p95,
    output logic [lj_pkg::SAMPLE_W-1:0] p99
);
    import lj_pkg::*;

    typedef enum logic [1:0] {
        SEL_IDLE = 2'b01,
        SEL_RUN  = 2'b10
    } sel_state_t;

    sel_state_t          state_reg;
    logic [SAMPLE_W-1:0] win_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [FILL_W-1:0]   addr_reg;
    logic [FILL_W-1:0]   n_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [SAMPLE_W-1:0] r95_reg;
    logic [SAMPLE_W-1:0] r99_reg;
    logic [FILL_W-1:0]   k95_reg;
    logic [FILL_W-1:0]   k99_reg;
    logic [FILL_W-1:0]   c95_reg;
    logic [FILL_W-1:0]   c99_reg;
    logic                done_reg;
    logic [SAMPLE_W-1:0] hi_mask;
    logic [SAMPLE_W-1:0] bit_one;
    logic                m95;
    logic                m99;
    logic                pass_end;

    // Window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wen)
            win_mem[waddr] <= wdata;
        rd_data_reg <= win_mem[addr_reg[IDX_W-1:0]];
    end

    // Count entries sharing the decided prefix with a zero in the current bit
    always_comb
    begin
        hi_mask  = ({SAMPLE_W{1'b1}} << bit_reg) << 1;
        bit_one  = {{(SAMPLE_W-1){1'b0}}, 1'b1} << bit_reg;
        m95      = rd_valid_reg && (((rd_data_reg ^ r95_reg) & hi_mask) == '0)
                   && !rd_data_reg[bit_reg];
        m99      = rd_valid_reg && (((rd_data_reg ^ r99_reg) & hi_mask) == '0)
                   && !rd_data_reg[bit_reg];
        pass_end = (addr_reg == n_reg) && !rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEL_IDLE;
            rd_valid_reg <= 1'b0;
            addr_reg     <= '0;
            n_reg        <= '0;
            bit_reg      <= '0;
            r95_reg      <= '0;
            r99_reg      <= '0;
            k95_reg      <= '0;
            k99_reg      <= '0;
            c95_reg      <= '0;
            c99_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            // Flag the end of the last pass
            done_reg <= (state_reg == SEL_RUN) && pass_end && (bit_reg == '0);
            unique case (state_reg)
                SEL_IDLE:
                begin
                    if (start)
                    begin
                        state_reg    <= SEL_RUN;
                        n_reg        <= fill;
                        k95_reg      <= RANK95_TAB[fill];
                        k99_reg      <= RANK99_TAB[fill];
                        bit_reg      <= BIT_W'(SAMPLE_W - 1);
                        r95_reg      <= '0;
                        r99_reg      <= '0;
                        c95_reg      <= '0;
                        c99_reg      <= '0;
                        addr_reg     <= '0;
                        rd_valid_reg <= 1'b0;
                    end
                end
                SEL_RUN:
                begin
                    // Sweep the filled slots
                    if (addr_reg < n_reg)
                    begin
                        addr_reg     <= addr_reg + 1'b1;
                        rd_valid_reg <= 1'b1;
                    end
                    else
                        rd_valid_reg <= 1'b0;
                    // Decide one bit of each result at the end of a pass
                    if (pass_end)
                    begin
                        if (k95_reg >= c95_reg)
                        begin
                            r95_reg <= r95_reg | bit_one;
                            k95_reg <= k95_reg - c95_reg;
                        end
                        if (k99_reg >= c99_reg)
                        begin
                            r99_reg <= r99_reg | bit_one;
                            k99_reg <= k99_reg - c99_reg;
                        end
                        c95_reg  <= '0;
                        c99_reg  <= '0;
                        addr_reg <= '0;
                        if (bit_reg == '0)
                            state_reg <= SEL_IDLE;
                        else
                            bit_reg <= bit_reg - 1'b1;
                    end
                    else
                    begin
                        c95_reg <= c95_reg + FILL_W'(m95);
                        c99_reg <= c99_reg + FILL_W'(m99);
                    end
                end
                default:
                    state_reg <= SEL_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign p95  = r95_reg;
    assign p99  = r99_reg;
endmodule
